// File: design/stdp_pkg.sv
// ----------------------------------------------------------------------------
// stdp_pkg
// Shared types, microcode format, program ROM and saturation helper for the
// STDP synapse trace unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stdp_pkg;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_EMIT = 4'd10;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	localparam int ADDR_W   = 5;

	typedef enum logic [2:0] {
		REG_POST_TARGET = 3'd0,
		REG_PRE_TARGET  = 3'd1,
		REG_GAIN_PLUS   = 3'd2,
		REG_GAIN_MINUS  = 3'd3,
		REG_POST_RATE   = 3'd4,
		REG_PRE_RATE    = 3'd5,
		REG_STEP_SCALE  = 3'd6,
		REG_RESISTANCE  = 3'd7
	} reg_idx_t;

	// operand A of the multiplier (33 bit signed)
	typedef enum logic [2:0] {
		A_ZERO,
		A_POST_ERR,
		A_PRE_ERR,
		A_POST_TRACE,
		A_PRE_TRACE,
		A_TERM_DIFF,
		A_INFL
	} a_sel_t;

	// operand B of the multiplier (unsigned, zero extended)
	typedef enum logic [2:0] {
		B_POST_RATE,
		B_PRE_RATE,
		B_GAIN_PLUS,
		B_GAIN_MINUS,
		B_STEP_SCALE,
		B_RES
	} b_sel_t;

	// writeback destination
	typedef enum logic [2:0] {
		W_NONE,
		W_POST_TRACE,
		W_PRE_TRACE,
		W_POST_TERM,
		W_PRE_TERM,
		W_DIFF,
		W_INFL,
		W_OUT
	} wb_t;

	// wait conditions: when true, the step has no effect and jumps to target
	typedef enum logic [1:0] {
		C_NEVER,
		C_NO_INPUT,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              last;
		logic              accept;
		logic              mul_en;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		wb_t               wb;
	} ctrl_word_t;

	typedef struct packed {
		logic signed [31:0] post_target;
		logic signed [31:0] pre_target;
		logic [30:0]        gain_plus;
		logic [30:0]        gain_minus;
		logic [16:0]        post_rate;
		logic [16:0]        pre_rate;
		logic [16:0]        step_scale;
		logic [30:0]        resistance;
	} cfg_t;

	// Program. A multiply issued in step n is written back in step n+1.
	function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		w = '{C_NEVER, STEP_IDLE, 1'b1, 1'b0, 1'b0, A_ZERO, B_POST_RATE, W_NONE};
		case (step)
			4'd0: w = '{C_NO_INPUT, STEP_IDLE, 1'b0, 1'b1, 1'b0, A_ZERO, B_POST_RATE, W_NONE};
			4'd1: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b1, A_POST_ERR, B_POST_RATE, W_NONE};
			4'd2: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b1, A_PRE_ERR, B_PRE_RATE,
				W_POST_TRACE};
			4'd3: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b1, A_POST_TRACE, B_GAIN_PLUS,
				W_PRE_TRACE};
			4'd4: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b1, A_PRE_TRACE, B_GAIN_MINUS,
				W_POST_TERM};
			4'd5: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b0, A_ZERO, B_POST_RATE, W_PRE_TERM};
			4'd6: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b1, A_TERM_DIFF, B_STEP_SCALE, W_NONE};
			4'd7: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b0, A_ZERO, B_POST_RATE, W_DIFF};
			4'd8: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b0, A_ZERO, B_POST_RATE, W_INFL};
			4'd9: w = '{C_NEVER, STEP_IDLE, 1'b0, 1'b0, 1'b1, A_INFL, B_RES, W_NONE};
			4'd10: w = '{C_OUT_BUSY, STEP_EMIT, 1'b1, 1'b0, 1'b0, A_ZERO, B_POST_RATE, W_OUT};
			default: w = '{C_NEVER, STEP_IDLE, 1'b1, 1'b0, 1'b0, A_ZERO, B_POST_RATE, W_NONE};
		endcase
		return w;
	endfunction

	// clamp a 49 bit signed value to the signed 32 bit range
	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v[48:31] == {18{v[48]}}) begin
			r = v[31:0];
		end else if (v[48]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/stdp_cfg_regs.sv
// ----------------------------------------------------------------------------
// stdp_cfg_regs
// APB register file holding the eight rule parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_cfg_regs (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [stdp_pkg::ADDR_W-1:0]      paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output stdp_pkg::cfg_t                   cfg
);

	stdp_pkg::cfg_t   cfg_q;
	stdp_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = stdp_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.post_target <= stdp_pkg::ONE_Q16;
			cfg_q.pre_target  <= stdp_pkg::ONE_Q16;
			cfg_q.gain_plus   <= 31'd65536;
			cfg_q.gain_minus  <= 31'd65536;
			cfg_q.post_rate   <= 17'd6554;
			cfg_q.pre_rate    <= 17'd65536;
			cfg_q.step_scale  <= 17'd66;
			cfg_q.resistance  <= 31'd65536;
		end else if (wr_en) begin
			case (idx)
				stdp_pkg::REG_POST_TARGET: cfg_q.post_target <= pwdata;
				stdp_pkg::REG_PRE_TARGET:  cfg_q.pre_target  <= pwdata;
				stdp_pkg::REG_GAIN_PLUS:   cfg_q.gain_plus   <= pwdata[30:0];
				stdp_pkg::REG_GAIN_MINUS:  cfg_q.gain_minus  <= pwdata[30:0];
				stdp_pkg::REG_POST_RATE:   cfg_q.post_rate   <= pwdata[16:0];
				stdp_pkg::REG_PRE_RATE:    cfg_q.pre_rate    <= pwdata[16:0];
				stdp_pkg::REG_STEP_SCALE:  cfg_q.step_scale  <= pwdata[16:0];
				stdp_pkg::REG_RESISTANCE:  cfg_q.resistance  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			stdp_pkg::REG_POST_TARGET: prdata = cfg_q.post_target;
			stdp_pkg::REG_PRE_TARGET:  prdata = cfg_q.pre_target;
			stdp_pkg::REG_GAIN_PLUS:   prdata = {1'b0, cfg_q.gain_plus};
			stdp_pkg::REG_GAIN_MINUS:  prdata = {1'b0, cfg_q.gain_minus};
			stdp_pkg::REG_POST_RATE:   prdata = {15'd0, cfg_q.post_rate};
			stdp_pkg::REG_PRE_RATE:    prdata = {15'd0, cfg_q.pre_rate};
			stdp_pkg::REG_STEP_SCALE:  prdata = {15'd0, cfg_q.step_scale};
			stdp_pkg::REG_RESISTANCE:  prdata = {1'b0, cfg_q.resistance};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// File: design/stdp_sequencer.sv
// ----------------------------------------------------------------------------
// stdp_sequencer
// Step counter and program ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_sequencer (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   out_busy,
	output logic                  in_ready,
	output stdp_pkg::ctrl_word_t  ctrl
);

	logic [stdp_pkg::STEP_W-1:0] upc_q;
	logic [stdp_pkg::STEP_W-1:0] upc_nxt;
	stdp_pkg::ctrl_word_t        word;
	logic                        hold;

	assign word     = stdp_pkg::ucode_rom(upc_q);
	assign in_ready = word.accept;

	always_comb begin
		case (word.cond)
			stdp_pkg::C_NO_INPUT: hold = !in_valid;
			stdp_pkg::C_OUT_BUSY: hold = out_busy;
			default:              hold = 1'b0;
		endcase
	end

	always_comb begin
		if (hold) begin
			upc_nxt = word.target;
		end else if (word.last) begin
			upc_nxt = stdp_pkg::STEP_IDLE;
		end else begin
			upc_nxt = upc_q + 1'b1;
		end
	end

	// a waiting step has no side effects
	always_comb begin
		ctrl = word;
		if (hold) begin
			ctrl.accept = 1'b0;
			ctrl.mul_en = 1'b0;
			ctrl.wb     = stdp_pkg::W_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= stdp_pkg::STEP_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

`default_nettype wire

// File: design/stdp_datapath.sv
// ----------------------------------------------------------------------------
// stdp_datapath
// Shared multiplier, round/accumulate/saturate writeback, state and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_datapath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  stdp_pkg::ctrl_word_t  ctrl,
	input  stdp_pkg::cfg_t        cfg,
	input  wire                   pre_spike,
	input  wire                   post_spike,
	input  wire                   out_ready,
	output logic                  out_valid,
	output logic signed [31:0]    influence,
	output logic signed [31:0]    drive
);

	logic signed [31:0] post_trace_q, pre_trace_q, wd_q;
	logic signed [31:0] post_term_q, pre_term_q, infl_q;
	logic               pre_spk_q, post_spk_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] influence_q, drive_q;
	logic               out_valid_q;

	logic signed [32:0] op_a;
	logic signed [31:0] op_b;
	logic signed [64:0] prod_full;
	logic signed [31:0] post_goal, pre_goal;
	logic signed [63:0] prod_rnd;
	logic signed [31:0] base;
	logic signed [48:0] sum;
	logic signed [31:0] wb_val;
	logic signed [31:0] infl_new;

	assign post_goal = post_spk_q ? cfg.post_target : 32'sd0;
	assign pre_goal  = pre_spk_q ? cfg.pre_target : 32'sd0;

	always_comb begin
		case (ctrl.a_sel)
			stdp_pkg::A_POST_ERR:   op_a = {post_goal[31], post_goal}
				- {post_trace_q[31], post_trace_q};
			stdp_pkg::A_PRE_ERR:    op_a = {pre_goal[31], pre_goal}
				- {pre_trace_q[31], pre_trace_q};
			stdp_pkg::A_POST_TRACE: op_a = {post_trace_q[31], post_trace_q};
			stdp_pkg::A_PRE_TRACE:  op_a = {pre_trace_q[31], pre_trace_q};
			stdp_pkg::A_TERM_DIFF:  op_a = {post_term_q[31], post_term_q}
				- {pre_term_q[31], pre_term_q};
			stdp_pkg::A_INFL:       op_a = {infl_q[31], infl_q};
			default:                op_a = 33'sd0;
		endcase
	end

	always_comb begin
		case (ctrl.b_sel)
			stdp_pkg::B_POST_RATE:  op_b = {15'd0, cfg.post_rate};
			stdp_pkg::B_PRE_RATE:   op_b = {15'd0, cfg.pre_rate};
			stdp_pkg::B_GAIN_PLUS:  op_b = {1'b0, cfg.gain_plus};
			stdp_pkg::B_GAIN_MINUS: op_b = {1'b0, cfg.gain_minus};
			stdp_pkg::B_STEP_SCALE: op_b = {15'd0, cfg.step_scale};
			stdp_pkg::B_RES:        op_b = {1'b0, cfg.resistance};
			default:                op_b = 32'sd0;
		endcase
	end

	// every product used here fits in 63 bits
	assign prod_full = op_a * op_b;

	// round half up, then shift out the 16 fraction bits
	assign prod_rnd = prod_q + 64'sd32768;

	always_comb begin
		case (ctrl.wb)
			stdp_pkg::W_POST_TRACE: base = post_trace_q;
			stdp_pkg::W_PRE_TRACE:  base = pre_trace_q;
			stdp_pkg::W_DIFF:       base = wd_q;
			default:                base = 32'sd0;
		endcase
	end

	assign sum      = {{17{base[31]}}, base} + {prod_rnd[63], prod_rnd[63:16]};
	assign wb_val   = stdp_pkg::sat32(sum);
	assign infl_new = stdp_pkg::sat32({{17{stdp_pkg::ONE_Q16[31]}}, stdp_pkg::ONE_Q16}
		- {{17{wd_q[31]}}, wd_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_trace_q <= 32'sd0;
			pre_trace_q  <= 32'sd0;
			wd_q         <= 32'sd0;
			out_valid_q  <= 1'b0;
		end else begin
			case (ctrl.wb)
				stdp_pkg::W_POST_TRACE: post_trace_q <= wb_val;
				stdp_pkg::W_PRE_TRACE:  pre_trace_q  <= wb_val;
				stdp_pkg::W_DIFF:       wd_q         <= wb_val;
				default: ;
			endcase
			if (ctrl.wb == stdp_pkg::W_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			pre_spk_q  <= pre_spike;
			post_spk_q <= post_spike;
		end
		if (ctrl.mul_en) begin
			prod_q <= prod_full[63:0];
		end
		case (ctrl.wb)
			stdp_pkg::W_POST_TERM: post_term_q <= post_spk_q ? wb_val : 32'sd0;
			stdp_pkg::W_PRE_TERM:  pre_term_q  <= pre_spk_q ? wb_val : 32'sd0;
			stdp_pkg::W_INFL:      infl_q      <= infl_new;
			stdp_pkg::W_OUT: begin
				influence_q <= infl_q;
				drive_q     <= wb_val;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign influence = influence_q;
	assign drive     = drive_q;

endmodule

`default_nettype wire

// File: design/stdp_synapse_trace_update.sv
// ----------------------------------------------------------------------------
// stdp_synapse_trace_update
// Pair-based STDP trace rule: per tick trace update, weight difference
// accumulation and influence/drive output, in signed Q16.16.
// ----------------------------------------------------------------------------
// Each input transfer is one simulation tick carrying a pre and a post spike
// bit; each tick yields exactly one output transfer with influence and drive.
// A microcoded sequencer steps a single 33x32 multiplier and one
// round/add/saturate writeback through an eleven-step program: the idle
// step that takes the transfer, then ten steps for the six chained
// multiplies (post trace, pre trace, two gain terms, difference increment,
// drive) and the influence subtraction. The output register is loaded in
// the final step. A new tick is taken while the last result is still waiting
// in the output register; the program only holds at its final step if that
// register is still occupied. Configuration writes over APB take effect at
// once and are meant to be done while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_synapse_trace_update (
	input  wire         clk,
	input  wire         arst_n,

	// tick input
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [0] pre_spike, [1] post_spike, [7:2] zero

	// result output
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // [31:0] influence, [63:32] drive

	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	stdp_pkg::cfg_t       cfg;
	stdp_pkg::ctrl_word_t ctrl;
	logic                 out_valid;
	logic                 out_busy;
	logic signed [31:0]   influence;
	logic signed [31:0]   drive;

	// output register still holds a result nobody took this cycle
	assign out_busy = out_valid && !m_tready;

	stdp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	stdp_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_busy (out_busy),
		.in_ready (s_tready),
		.ctrl     (ctrl)
	);

	stdp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg        (cfg),
		.pre_spike  (s_tdata[0]),
		.post_spike (s_tdata[1]),
		.out_ready  (m_tready),
		.out_valid  (out_valid),
		.influence  (influence),
		.drive      (drive)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {drive, influence};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the STDP synapse trace unit.
// ----------------------------------------------------------------------------
// Tick transfers go in on the s_ stream. A scoreboard model runs the same
// Q16.16 trace, gain-term and weight-difference arithmetic, and it queues the
// influence/drive pair that each tick should give. Every m_ transfer is
// compared field by field against the oldest queued pair. Register settings
// are changed over APB only while the unit is drained. The stimulus is a run
// under the reset settings, a directed set of extreme settings, then random
// phases. Each random phase has its own settings and spike densities. Random
// gaps and stalls are applied on both streams outside the steady third phase.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_TICKS  = 850;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] pre_spike, [1] post_spike, [7:2] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [31:0] influence, [63:32] drive
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	typedef struct {
		logic [31:0] influence;
		logic [31:0] drive;
	} tick_result_t;

	tick_result_t expected_outputs[$];

	// scoreboard copy of the register file (values already masked)
	longint tgt_post, tgt_pre, gain_pot, gain_dep;
	longint rate_post, rate_pre, diff_scale, res_gain;
	// scoreboard copy of the unit state
	longint trace_post, trace_pre, wdiff;

	bit steady;   // no gaps and no stalls while set
	int cycle_count;
	int ticks_sent, results_seen, mismatches, reg_writes, settings_used;

	stdp_synapse_trace_update i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// >>> on a signed value floors, so this is round half toward +inf
	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint step_trace(longint tr, bit spike, longint target, longint rate);
		longint goal;
		goal = spike ? target : 64'sd0;
		return clamp32(tr + round_q16((goal - tr) * rate));
	endfunction

	// advances the scoreboard state by one tick and returns its output pair
	function automatic tick_result_t predict_tick(bit pre, bit post);
		longint post_term, pre_term, infl, drv;
		tick_result_t r;
		trace_post = step_trace(trace_post, post, tgt_post, rate_post);
		trace_pre  = step_trace(trace_pre, pre, tgt_pre, rate_pre);
		// term uses the freshly updated trace
		post_term  = post ? clamp32(round_q16(trace_post * gain_pot)) : 64'sd0;
		pre_term   = pre ? clamp32(round_q16(trace_pre * gain_dep)) : 64'sd0;
		wdiff      = clamp32(wdiff + round_q16((post_term - pre_term) * diff_scale));
		infl       = clamp32(longint'(stdp_pkg::ONE_Q16) - wdiff);
		drv        = clamp32(round_q16(infl * res_gain));
		r.influence = infl[31:0];
		r.drive     = drv[31:0];
		return r;
	endfunction

	function automatic void model_reset();
		tgt_post   = 65536;
		tgt_pre    = 65536;
		gain_pot   = 65536;
		gain_dep   = 65536;
		rate_post  = 6554;
		rate_pre   = 65536;
		diff_scale = 66;
		res_gain   = 65536;
		trace_post = 0;
		trace_pre  = 0;
		wdiff      = 0;
	endfunction

	function automatic void model_write(stdp_pkg::reg_idx_t idx, logic [31:0] value);
		case (idx)
			stdp_pkg::REG_POST_TARGET: tgt_post   = longint'($signed(value));
			stdp_pkg::REG_PRE_TARGET:  tgt_pre    = longint'($signed(value));
			stdp_pkg::REG_GAIN_PLUS:   gain_pot   = longint'({33'd0, value[30:0]});
			stdp_pkg::REG_GAIN_MINUS:  gain_dep   = longint'({33'd0, value[30:0]});
			stdp_pkg::REG_POST_RATE:   rate_post  = longint'({47'd0, value[16:0]});
			stdp_pkg::REG_PRE_RATE:    rate_pre   = longint'({47'd0, value[16:0]});
			stdp_pkg::REG_STEP_SCALE:  diff_scale = longint'({47'd0, value[16:0]});
			stdp_pkg::REG_RESISTANCE:  res_gain   = longint'({33'd0, value[30:0]});
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic apb_write(stdp_pkg::reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		model_write(idx, value);
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// one tick transfer; prediction is made at the accepting edge
	task automatic send_tick(bit pre, bit post);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 9) begin
			gap = $urandom_range(1, 20);
		end
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, post, pre};
		do @(posedge clk); while (!s_tready);
		expected_outputs.push_back(predict_tick(pre, post));
		ticks_sent++;
	endtask

	// drop valid and hold off until every queued result has come back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_outputs.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 9);
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		tick_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_outputs.size() == 0) begin
				mismatches++;
				$error("unexpected result transfer: influence %h drive %h",
					m_tdata[31:0], m_tdata[63:32]);
			end else begin
				exp_r = expected_outputs.pop_front();
				if (m_tdata[31:0] !== exp_r.influence) begin
					mismatches++;
					$error("influence: expected %h, got %h", exp_r.influence,
						m_tdata[31:0]);
				end
				if (m_tdata[63:32] !== exp_r.drive) begin
					mismatches++;
					$error("drive: expected %h, got %h", exp_r.drive, m_tdata[63:32]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_outputs.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// reset settings, every spike combination
	task automatic test_reset_defaults();
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		drain_results();
		settings_used++;
	endtask

	// field extremes, rates above one, masked upper write bits, all-zero gains
	task automatic test_extreme_settings();
		// extreme targets, gains at max via bit 31 junk, overshooting rates
		apb_write(stdp_pkg::REG_POST_TARGET, 32'h7FFF_FFFF);
		apb_write(stdp_pkg::REG_PRE_TARGET,  32'h8000_0000);
		apb_write(stdp_pkg::REG_GAIN_PLUS,   32'hFFFF_FFFF);
		apb_write(stdp_pkg::REG_GAIN_MINUS,  32'hFFFF_FFFF);
		apb_write(stdp_pkg::REG_POST_RATE,   32'hFFFF_FFFF);
		apb_write(stdp_pkg::REG_PRE_RATE,    32'h0001_FFFF);
		apb_write(stdp_pkg::REG_STEP_SCALE,  32'h0001_FFFF);
		apb_write(stdp_pkg::REG_RESISTANCE,  32'h7FFF_FFFF);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		drain_results();
		settings_used++;

		// rates, gains, scale and resistance zero: traces frozen, no increment, no drive
		apb_write(stdp_pkg::REG_POST_TARGET, 32'h8000_0000);
		apb_write(stdp_pkg::REG_PRE_TARGET,  32'h7FFF_FFFF);
		apb_write(stdp_pkg::REG_GAIN_PLUS,   32'h0000_0000);
		apb_write(stdp_pkg::REG_GAIN_MINUS,  32'h8000_0000);
		apb_write(stdp_pkg::REG_POST_RATE,   32'h0000_0000);
		apb_write(stdp_pkg::REG_PRE_RATE,    32'hFFFE_0000);
		apb_write(stdp_pkg::REG_STEP_SCALE,  32'h0000_0000);
		apb_write(stdp_pkg::REG_RESISTANCE,  32'h0000_0000);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		drain_results();
		settings_used++;

		// unit rate and scale, drive the difference into both rails
		apb_write(stdp_pkg::REG_POST_TARGET, 32'h7FFF_FFFF);
		apb_write(stdp_pkg::REG_PRE_TARGET,  32'h7FFF_FFFF);
		apb_write(stdp_pkg::REG_GAIN_PLUS,   32'h7FFF_FFFF);
		apb_write(stdp_pkg::REG_GAIN_MINUS,  32'h7FFF_FFFF);
		apb_write(stdp_pkg::REG_POST_RATE,   32'h0001_0000);
		apb_write(stdp_pkg::REG_PRE_RATE,    32'h0001_0000);
		apb_write(stdp_pkg::REG_STEP_SCALE,  32'h0001_0000);
		apb_write(stdp_pkg::REG_RESISTANCE,  32'h7FFF_FFFF);
		repeat (3) send_tick(1'b0, 1'b1);
		repeat (3) send_tick(1'b1, 1'b0);
		drain_results();
		settings_used++;
	endtask

	function automatic logic [31:0] pick_setting(stdp_pkg::reg_idx_t idx);
		int unsigned roll;
		roll = $urandom_range(9);
		case (idx)
			stdp_pkg::REG_POST_TARGET, stdp_pkg::REG_PRE_TARGET: begin
				case (roll)
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return $urandom();
					default: return 32'($urandom_range(0, 524288)) - 32'd262144;
				endcase
			end
			stdp_pkg::REG_POST_RATE, stdp_pkg::REG_PRE_RATE, stdp_pkg::REG_STEP_SCALE: begin
				case (roll)
					0: return 32'd0;
					1: return 32'h0001_FFFF;
					2: return 32'($urandom_range(65537, 131071));
					3: return 32'd65536;
					4: return $urandom();
					default: return 32'($urandom_range(1, 65536));
				endcase
			end
			default: begin
				// gains and resistance
				case (roll)
					0: return 32'd0;
					1: return 32'hFFFF_FFFF;
					2: return $urandom();
					default: return 32'($urandom_range(0, 524288));
				endcase
			end
		endcase
	endfunction

	// random phases, each with its own settings and spike densities
	task automatic test_random_ticks();
		int sent, phase, phase_len, pre_pct, post_pct;
		stdp_pkg::reg_idx_t idx;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_TICKS) begin
			idx = idx.first();
			do begin
				apb_write(idx, pick_setting(idx));
				idx = idx.next();
			end while (idx != idx.first());
			settings_used++;
			phase_len = $urandom_range(80, 130);
			pre_pct   = $urandom_range(5, 70);
			post_pct  = $urandom_range(5, 70);
			steady    = (phase == 2);
			for (int k = 0; k < phase_len && sent < RANDOM_TICKS; k++) begin
				// mid-phase hold-off until the unit has caught up
				if (phase == 4 && k == phase_len / 2) begin
					drain_results();
				end
				send_tick($urandom_range(99) < pre_pct, $urandom_range(99) < post_pct);
				sent++;
			end
			drain_results();
			steady = 1'b0;
			phase++;
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		steady   = 1'b0;
		model_reset();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_extreme_settings();
		test_random_ticks();

		drain_results();
		// idle with nothing expected; any stray result transfer is flagged
		repeat (20) @(posedge clk);

		$display("Run covered %0d ticks under %0d register settings (%0d APB writes).",
			ticks_sent, settings_used, reg_writes);
		$display("%0d result transfers checked, %0d field mismatches.", results_seen,
			mismatches);
		if (mismatches == 0 && expected_outputs.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: sim.f
design/stdp_pkg.sv
design/stdp_cfg_regs.sv
design/stdp_sequencer.sv
design/stdp_datapath.sv
design/stdp_synapse_trace_update.sv
tb/tb_top.sv
